[sv/lip_pkg.sv]
// lip_pkg: shared types, predictor mode codes and per-lane pixel helpers
// for the lossless inverse predictor. No dependencies.
`timescale 1ns / 1ps

package lip_pkg;

    // Predictor mode codes
    localparam logic [3:0] MODE_BLACK     = 4'd0;
    localparam logic [3:0] MODE_LEFT      = 4'd1;
    localparam logic [3:0] MODE_TOP       = 4'd2;
    localparam logic [3:0] MODE_TOP_RIGHT = 4'd3;
    localparam logic [3:0] MODE_TOP_LEFT  = 4'd4;
    localparam logic [3:0] MODE_AVG_LTR_T = 4'd5;
    localparam logic [3:0] MODE_AVG_L_TL  = 4'd6;
    localparam logic [3:0] MODE_AVG_L_T   = 4'd7;
    localparam logic [3:0] MODE_AVG_TL_T  = 4'd8;
    localparam logic [3:0] MODE_AVG_T_TR  = 4'd9;
    localparam logic [3:0] MODE_AVG_QUAD  = 4'd10;
    localparam logic [3:0] MODE_SELECT    = 4'd11;
    localparam logic [3:0] MODE_ADD_FULL  = 4'd12;
    localparam logic [3:0] MODE_ADD_HALF  = 4'd13;

    // Pixel constants
    localparam logic [31:0] LANE_MASK_HALF = 32'hFEFE_FEFE;
    localparam logic [31:0] MASK_AG        = 32'hFF00_FF00;
    localparam logic [31:0] MASK_RB        = 32'h00FF_00FF;
    localparam logic [31:0] BLACK_PIXEL    = 32'hFF00_0000;
    localparam logic [7:0]  LANE_MAX       = 8'hFF;

    typedef logic [31:0] pixel_t;

    // Neighbor pixels of the current position
    typedef struct packed {
        pixel_t left;
        pixel_t top;
        pixel_t top_left;
        pixel_t top_right;
    } nbr_t;

    // Per-lane truncating average
    function automatic pixel_t avg2(input pixel_t a, input pixel_t b);
        return (((a ^ b) & LANE_MASK_HALF) >> 1) + (a & b);
    endfunction

    // Per-lane add with wrap
    function automatic pixel_t lane_add(input pixel_t a, input pixel_t b);
        pixel_t ag;
        pixel_t rb;
        ag = (a & MASK_AG) + (b & MASK_AG);
        rb = (a & MASK_RB) + (b & MASK_RB);
        return (ag & MASK_AG) | (rb & MASK_RB);
    endfunction

    // Clamp a signed lane value in -512..511 to 0..255
    function automatic logic [7:0] clip8(input logic signed [9:0] v);
        logic [7:0] r;
        if (v[9])
        begin
            r = 8'd0;
        end
        else if (v[8])
        begin
            r = LANE_MAX;
        end
        else
        begin
            r = v[7:0];
        end
        return r;
    endfunction

endpackage

[sv/lip_predictor.sv]
// lip_predictor: combinational prediction for one pixel from its
// neighbors and the mode code. Depends on lip_pkg.
`timescale 1ns / 1ps

module lip_predictor
(
    input  logic [3:0]     command,
    input  lip_pkg::nbr_t  nbr,
    output lip_pkg::pixel_t pred
);

    lip_pkg::pixel_t avg_l_tr;
    lip_pkg::pixel_t avg_l_tl;
    lip_pkg::pixel_t avg_l_t;
    lip_pkg::pixel_t avg_tl_t;
    lip_pkg::pixel_t avg_t_tr;
    lip_pkg::pixel_t full_pred;
    lip_pkg::pixel_t half_pred;
    logic [7:0]      abs_l [4];
    logic [7:0]      abs_t [4];
    logic [9:0]      sum_l;
    logic [9:0]      sum_t;

    // Shared averages
    assign avg_l_tr = lip_pkg::avg2(nbr.left, nbr.top_right);
    assign avg_l_tl = lip_pkg::avg2(nbr.left, nbr.top_left);
    assign avg_l_t  = lip_pkg::avg2(nbr.left, nbr.top);
    assign avg_tl_t = lip_pkg::avg2(nbr.top_left, nbr.top);
    assign avg_t_tr = lip_pkg::avg2(nbr.top, nbr.top_right);

    // Per-lane gradient, clamped add-subtract and select distances
    for (genvar g = 0; g < 4; g++)
    begin : g_lane
        logic [7:0]        l8;
        logic [7:0]        t8;
        logic [7:0]        tl8;
        logic [7:0]        a8;
        logic signed [9:0] grad;
        logic signed [8:0] dl;
        logic signed [8:0] dt;
        logic signed [8:0] dh;
        logic signed [8:0] dh_round;
        logic signed [8:0] dh_half;
        logic signed [9:0] half_sum;

        assign l8  = nbr.left[8*g +: 8];
        assign t8  = nbr.top[8*g +: 8];
        assign tl8 = nbr.top_left[8*g +: 8];
        assign a8  = avg_l_t[8*g +: 8];

        // L + T - TL, clamp
        assign grad = $signed({2'b00, l8}) + $signed({2'b00, t8})
                    - $signed({2'b00, tl8});
        assign full_pred[8*g +: 8] = lip_pkg::clip8(grad);

        // a + (a - TL) / 2, halving toward zero, clamp
        assign dh       = $signed({1'b0, a8}) - $signed({1'b0, tl8});
        assign dh_round = dh + $signed({8'd0, dh[8]});
        assign dh_half  = dh_round >>> 1;
        assign half_sum = $signed({2'b00, a8}) + $signed({dh_half[8], dh_half});
        assign half_pred[8*g +: 8] = lip_pkg::clip8(half_sum);

        // Lane distances from TL
        assign dl = $signed({1'b0, l8}) - $signed({1'b0, tl8});
        assign dt = $signed({1'b0, t8}) - $signed({1'b0, tl8});
        assign abs_l[g] = dl[8] ? 8'(-dl) : dl[7:0];
        assign abs_t[g] = dt[8] ? 8'(-dt) : dt[7:0];
    end

    // Sum distances over lanes
    assign sum_l = 10'(abs_l[0]) + 10'(abs_l[1]) + 10'(abs_l[2]) + 10'(abs_l[3]);
    assign sum_t = 10'(abs_t[0]) + 10'(abs_t[1]) + 10'(abs_t[2]) + 10'(abs_t[3]);

    // Pick the prediction for the mode
    always_comb
    begin
        case (command)
            lip_pkg::MODE_LEFT:      pred = nbr.left;
            lip_pkg::MODE_TOP:       pred = nbr.top;
            lip_pkg::MODE_TOP_RIGHT: pred = nbr.top_right;
            lip_pkg::MODE_TOP_LEFT:  pred = nbr.top_left;
            lip_pkg::MODE_AVG_LTR_T: pred = lip_pkg::avg2(avg_l_tr, nbr.top);
            lip_pkg::MODE_AVG_L_TL:  pred = avg_l_tl;
            lip_pkg::MODE_AVG_L_T:   pred = avg_l_t;
            lip_pkg::MODE_AVG_TL_T:  pred = avg_tl_t;
            lip_pkg::MODE_AVG_T_TR:  pred = avg_t_tr;
            lip_pkg::MODE_AVG_QUAD:  pred = lip_pkg::avg2(avg_l_tl, avg_t_tr);
            lip_pkg::MODE_SELECT:    pred = (sum_l <= sum_t) ? nbr.top : nbr.left;
            lip_pkg::MODE_ADD_FULL:  pred = full_pred;
            lip_pkg::MODE_ADD_HALF:  pred = half_pred;
            default:                 pred = lip_pkg::BLACK_PIXEL;
        endcase
    end

endmodule

[sv/lossless_inverse_predictor.sv]
// Channel | Dir | Beat contents (low bits first)
// s_axis  | in  | tdata: residual, top, top_left, top_right, left_seed
//         |     | tuser: command[3:0], row_start[4]
// m_axis  | out | tdata: pixel
//
// One pixel per cycle sustained while m_axis_tready is high; an accepted
// beat passes through the input register, then the result register. The
// left neighbor loop runs through prediction, lane add and last_pixel_reg.
// Reset (rst_n low, asynchronous) empties both registers and clears the
// left neighbor to zero. A stalled result holds one beat while one more
// beat waits in the input register.
// Top level; depends on lip_pkg and lip_predictor.
`timescale 1ns / 1ps

module lossless_inverse_predictor
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [159:0] s_axis_tdata,  // residual, top, top_left, top_right, left_seed
    input  logic [4:0]   s_axis_tuser,  // command[3:0], row_start[4]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [31:0]  m_axis_tdata   // pixel
);

    logic            in_valid_reg;
    logic            in_valid_next;
    logic [3:0]      cmd_reg;
    logic            row_start_reg;
    lip_pkg::pixel_t residual_reg;
    lip_pkg::pixel_t top_reg;
    lip_pkg::pixel_t top_left_reg;
    lip_pkg::pixel_t top_right_reg;
    lip_pkg::pixel_t left_seed_reg;
    logic            out_valid_reg;
    logic            out_valid_next;
    lip_pkg::pixel_t pixel_reg;
    lip_pkg::pixel_t last_pixel_reg;
    lip_pkg::pixel_t pixel_next;
    lip_pkg::pixel_t pred;
    lip_pkg::nbr_t   nbr;
    logic            in_fire;
    logic            advance;

    // Handshake
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign in_valid_next  = in_fire || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_axis_tready);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            last_pixel_reg <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                last_pixel_reg <= pixel_next;
            end
        end
    end

    // Capture the input beat
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg       <= s_axis_tuser[3:0];
            row_start_reg <= s_axis_tuser[4];
            residual_reg  <= s_axis_tdata[31:0];
            top_reg       <= s_axis_tdata[63:32];
            top_left_reg  <= s_axis_tdata[95:64];
            top_right_reg <= s_axis_tdata[127:96];
            left_seed_reg <= s_axis_tdata[159:128];
        end
    end

    // Neighbors: left comes from the seed at a run start
    assign nbr.left      = row_start_reg ? left_seed_reg : last_pixel_reg;
    assign nbr.top       = top_reg;
    assign nbr.top_left  = top_left_reg;
    assign nbr.top_right = top_right_reg;

    lip_predictor u_predictor
    (
        .command (cmd_reg),
        .nbr     (nbr),
        .pred    (pred)
    );

    // Reconstruct and hold the result beat
    assign pixel_next = lip_pkg::lane_add(residual_reg, pred);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pixel_reg <= pixel_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = pixel_reg;

    // The stored last pixel always matches the pending result
    a_last_matches_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> last_pixel_reg == pixel_reg)
        else $error("last pixel differs from pending result");

    // A held input beat is never dropped
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("input beat dropped while stalled");

    // Left mode with zero residual at a run start returns the seed
    a_seed_pass: assert property (@(posedge clk) disable iff (!rst_n)
        advance && row_start_reg && cmd_reg == lip_pkg::MODE_LEFT
            && residual_reg == '0 |=> pixel_reg == $past(left_seed_reg))
        else $error("seed not passed through in left mode");

endmodule
